/* hdl/u8sd_pkg.sv */
// package for the utf-8 stream decoder: field widths, byte masks and the decode result type
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 21;
  localparam int unsigned PendW    = 2;

  // lead byte class masks and match patterns
  localparam logic [ByteW-1:0] AsciiMask  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat   = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat   = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat   = 8'hF0;

  // replacement character for a bad lead byte
  localparam logic [CpW-1:0]   BadLeadCp  = 21'h00003F;

  // continuation counts
  localparam logic [PendW-1:0] PendNone   = 2'd0;
  localparam logic [PendW-1:0] PendOne    = 2'd1;
  localparam logic [PendW-1:0] PendTwo    = 2'd2;
  localparam logic [PendW-1:0] PendThree  = 2'd3;

  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   code_point;
    logic             string_end;
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
  } dec_res_t;

endpackage

/* hdl/utf8_stream_decoder_unit.sv */
// top level of the lenient utf-8 stream decoder: input register, decode, result register
`timescale 1ns / 1ps

//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, byte_in_i[7:0]    | sink
//  out     | out_valid_o, out_ready_i, code_point_o,   | source
//          | string_end_o                              |
//
// one byte per cycle sustained while no stalled result holds the input register; a
// byte's result, if any, is decoded from the input register into the result register
// reset clears the valid flags and the decode state (no bytes pending, partial zero)
// a stalled result holds the input register only while that register's byte would
// need to overwrite it; bytes that complete nothing still advance
module utf8_stream_decoder_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [u8sd_pkg::ByteW-1:0] byte_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u8sd_pkg::CpW-1:0]   code_point_o,
  output logic                       string_end_o
);
  import u8sd_pkg::*;

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] byte_q;

  // decode state
  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   part_q, part_d;

  // result register
  logic             out_vld_q, out_vld_d;
  logic [CpW-1:0]   cp_q;
  logic             end_q;

  dec_res_t res;
  logic     out_free;
  logic     advance;

  u8sd_decode u_decode (
    .byte_i    (byte_q),
    .pending_i (pend_q),
    .partial_i (part_q),
    .res_o     (res)
  );

  // result slot is free when empty or being taken this cycle
  assign out_free   = !out_vld_q || out_ready_i;
  // the held byte moves on unless it makes a result with nowhere to go
  assign advance    = in_vld_q && (out_free || !res.emit);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    pend_d    = pend_q;
    part_d    = part_q;
    out_vld_d = out_vld_q && !out_ready_i;
    if (advance) begin
      pend_d = res.pending;
      part_d = res.partial;
      if (res.emit) begin
        out_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pend_q    <= PendNone;
      part_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      pend_q    <= pend_d;
      part_q    <= part_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
    if (advance && res.emit) begin
      cp_q  <= res.code_point;
      end_q <= res.string_end;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign code_point_o = cp_q;
  assign string_end_o = end_q;

endmodule

/* hdl/u8sd_decode.sv */
// combinational next-state and result logic for one byte of the utf-8 stream
`timescale 1ns / 1ps

module u8sd_decode (
  input  logic [u8sd_pkg::ByteW-1:0] byte_i,
  input  logic [u8sd_pkg::PendW-1:0] pending_i,
  input  logic [u8sd_pkg::CpW-1:0]   partial_i,
  output u8sd_pkg::dec_res_t         res_o
);
  import u8sd_pkg::*;

  logic [CpW-1:0] payload;
  logic [CpW-1:0] merged;

  // low six bits of a continuation byte, placed by how many bytes remain
  always_comb begin
    payload = '0;
    case (pending_i)
      PendOne:   payload = {15'd0, byte_i[5:0]};
      PendTwo:   payload = {9'd0, byte_i[5:0], 6'd0};
      PendThree: payload = {3'd0, byte_i[5:0], 12'd0};
      default:   payload = '0;
    endcase
  end

  assign merged = partial_i | payload;

  always_comb begin
    res_o = '{emit: 1'b0, code_point: '0, string_end: 1'b0,
              pending: pending_i, partial: partial_i};
    if (pending_i != PendNone) begin
      res_o.partial = merged;
      res_o.pending = pending_i - PendOne;
      if (pending_i == PendOne) begin
        res_o.emit       = 1'b1;
        res_o.code_point = merged;
      end
    end else if (byte_i == '0) begin
      res_o.emit       = 1'b1;
      res_o.string_end = 1'b1;
    end else if ((byte_i & AsciiMask) == '0) begin
      res_o.emit       = 1'b1;
      res_o.code_point = {13'd0, byte_i};
    end else if ((byte_i & Lead2Mask) == Lead2Pat) begin
      res_o.partial = {10'd0, byte_i[4:0], 6'd0};
      res_o.pending = PendOne;
    end else if ((byte_i & Lead3Mask) == Lead3Pat) begin
      res_o.partial = {5'd0, byte_i[3:0], 12'd0};
      res_o.pending = PendTwo;
    end else if ((byte_i & Lead4Mask) == Lead4Pat) begin
      res_o.partial = {byte_i[2:0], 18'd0};
      res_o.pending = PendThree;
    end else begin
      res_o.emit       = 1'b1;
      res_o.code_point = BadLeadCp;
    end
  end

endmodule
